FILE: rtl/core/seed_key_feistel_cipher_assert.svh
// ----------------------------------------------------------------------------
// seed_key_feistel_cipher assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef SEED_KEY_FEISTEL_CIPHER_ASSERT_SVH
`define SEED_KEY_FEISTEL_CIPHER_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define SKFC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("skfc same-cycle check failed");

// Next-cycle implication, checked out of reset only.
`define SKFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("skfc next-cycle check failed");

`endif

FILE: rtl/core/skfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skfc_pkg
// Types, constants and the substitution table of the seed/key cipher.
// ----------------------------------------------------------------------------
package skfc_pkg;

    typedef logic [31:0] t_word;
    typedef logic [15:0] t_half;
    typedef logic [3:0]  t_nibble;

    localparam int NUM_ROUNDS       = 16;
    localparam int ROUNDS_PER_STAGE = 2;
    localparam int NUM_STAGES       = NUM_ROUNDS / ROUNDS_PER_STAGE;
    localparam int NUM_KEY_PAIRS    = NUM_ROUNDS / 2;
    localparam int KEY_IDX_W        = $clog2(NUM_KEY_PAIRS);
    localparam int CFG_IDX_W        = KEY_IDX_W + 1;
    localparam int NUM_NIBBLES      = 4;
    localparam int ROT_RIGHT        = 3;

    localparam t_nibble SBOX [32] = '{
        4'h5, 4'h6, 4'h7, 4'h1, 4'h9, 4'hC, 4'hD, 4'h8,
        4'hA, 4'hD, 4'h2, 4'hB, 4'hF, 4'h4, 4'h0, 4'h3,
        4'hB, 4'h4, 4'h6, 4'h0, 4'hF, 4'h2, 4'hD, 4'h9,
        4'h5, 4'hC, 4'h1, 4'hA, 4'h3, 4'hD, 4'hE, 4'h8
    };

    localparam t_word KEY_RESET [NUM_KEY_PAIRS] = '{
        32'hCA580FE9, 32'hDFF15E90, 32'hF591690B, 32'h5C7B1794,
        32'h98E5A7BF, 32'hA1C90B63, 32'hF41379BF, 32'hA89582B1
    };

endpackage

FILE: rtl/core/seed_key_feistel_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seed_key_feistel_cipher
// Sixteen-round Feistel challenge/response cipher, fully pipelined.
// ----------------------------------------------------------------------------
// The block turns a 32-bit challenge seed into a 32-bit response key. It takes
// one item per clock while o_in_stall is low, and returns the responses in order:
// the sixteen rounds are laid out as eight register stages of two rounds each.
// Each stage holds its item while the stage after it is full and stalled, so
// bubbles close up and the input keeps taking items while a finished response
// waits at the output. Round keys live in eight 32-bit registers written over
// the configuration port: register i holds round key 2i in bits 15:0 and round
// key 2i+1 in bits 31:16, and reset loads the standard key set. Writes to an
// index of 8 or above are accepted and dropped. Change keys only while the
// pipeline is empty; items in flight read the live registers.
// ----------------------------------------------------------------------------
module seed_key_feistel_cipher import skfc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // challenge channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [31:0]          i_challenge,
    // response channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [31:0]          o_response,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

`include "seed_key_feistel_cipher_assert.svh"

    t_half [NUM_ROUNDS-1:0]       round_key;
    t_half [ROUNDS_PER_STAGE-1:0] stage_key   [NUM_STAGES];
    logic                         stage_valid [NUM_STAGES];
    t_word                        stage_data  [NUM_STAGES];
    logic                         stage_stall [NUM_STAGES];
    logic                         stage_in_valid [NUM_STAGES];
    t_word                        stage_in_data  [NUM_STAGES];
    logic                         stage_out_stall [NUM_STAGES];
    t_word                        final_state;

    skfc_key_regs u_key_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_round_key (round_key)
    );

    // Rounds run from key 15 down to key 0: stage s applies keys
    // 15-2s and 14-2s in that order.
    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
        for (genvar j = 0; j < ROUNDS_PER_STAGE; j++) begin : g_key
            assign stage_key[s][j] = round_key[NUM_ROUNDS-1 - s*ROUNDS_PER_STAGE - j];
        end

        if (s == 0) begin : g_first
            assign stage_in_valid[s] = i_in_valid;
            assign stage_in_data[s]  = i_challenge;
        end else begin : g_next
            assign stage_in_valid[s] = stage_valid[s-1];
            assign stage_in_data[s]  = stage_data[s-1];
        end

        if (s == NUM_STAGES-1) begin : g_last
            assign stage_out_stall[s] = i_out_stall;
        end else begin : g_inner
            assign stage_out_stall[s] = stage_stall[s+1];
        end

        skfc_stage u_stage (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_valid     (stage_in_valid[s]),
            .i_data      (stage_in_data[s]),
            .i_round_key (stage_key[s]),
            .i_stall     (stage_out_stall[s]),
            .o_valid     (stage_valid[s]),
            .o_data      (stage_data[s]),
            .o_stall     (stage_stall[s])
        );
    end

    // Input stalls only when the first stage is full and cannot drain.
    assign o_in_stall  = stage_stall[0];

    // Final half swap is pure wiring on the last stage register.
    assign final_state = stage_data[NUM_STAGES-1];
    assign o_out_valid = stage_valid[NUM_STAGES-1];
    assign o_response  = {final_state[15:0], final_state[31:16]};

    // A stalled input always means the first stage is occupied.
    `SKFC_ASSERT_NOW(a_in_stall_full, o_in_stall, stage_valid[0])

    // With no output stall every stage moves on: the last valid follows
    // the one before it.
    `SKFC_ASSERT_NEXT(a_flow_free, !i_out_stall,
        o_out_valid == $past(stage_valid[NUM_STAGES-2]))

    // A first stage that is held keeps its item.
    `SKFC_ASSERT_NEXT(a_first_hold, stage_valid[0] && stage_stall[1],
        stage_valid[0] && $stable(stage_data[0]))

    // Writes beyond the key registers leave every round key untouched.
    `SKFC_ASSERT_NEXT(a_cfg_drop,
        i_cfg_valid && o_cfg_ready && (i_cfg_index >= CFG_IDX_W'(NUM_KEY_PAIRS)),
        $stable(round_key))

endmodule

FILE: rtl/core/skfc_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skfc_round
// One cipher round: key mix, four table lookups, rotate, Feistel swap.
// ----------------------------------------------------------------------------
module skfc_round import skfc_pkg::*; (
    input  t_word i_state,
    input  t_half i_key,
    output t_word o_state
);

    t_half       lo;
    t_half       hi;
    t_half       x;
    logic [31:0] dup;
    t_half       v;
    t_half       v_rot;

    assign lo  = i_state[15:0];
    assign hi  = i_state[31:16];
    assign x   = lo ^ i_key;
    assign dup = {x, x};

    // The top window wraps into bit 0 through the duplicated copy.
    always_comb begin
        for (int n = 0; n < NUM_NIBBLES; n++) begin
            v[n*4 +: 4] = SBOX[dup[n*4 +: 5]];
        end
    end

    assign v_rot   = {v[ROT_RIGHT-1:0], v[15:ROT_RIGHT]};
    assign o_state = {lo, v_rot ^ hi};

endmodule

FILE: rtl/core/skfc_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skfc_stage
// One pipeline stage: a chain of rounds followed by a data/valid register.
// ----------------------------------------------------------------------------
module skfc_stage import skfc_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  t_word                        i_data,
    input  t_half [ROUNDS_PER_STAGE-1:0] i_round_key,
    input  logic                         i_stall,
    output logic                         o_valid,
    output t_word                        o_data,
    output logic                         o_stall
);

    t_word chain [ROUNDS_PER_STAGE+1];
    t_word n_data;
    logic  load;
    logic  r_valid;
    t_word r_data;

    assign chain[0] = i_data;

    for (genvar j = 0; j < ROUNDS_PER_STAGE; j++) begin : g_round
        skfc_round u_round (
            .i_state (chain[j]),
            .i_key   (i_round_key[j]),
            .o_state (chain[j+1])
        );
    end

    assign n_data  = chain[ROUNDS_PER_STAGE];
    // Hold while full and the next stage will not take the item.
    assign o_stall = r_valid & i_stall;
    assign load    = ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/core/skfc_key_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skfc_key_regs
// Round key register file with its write port.
// ----------------------------------------------------------------------------
module skfc_key_regs import skfc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  t_word                  i_cfg_data,
    output logic                   o_cfg_ready,
    output t_half [NUM_ROUNDS-1:0] o_round_key
);

    t_word r_key_pair [NUM_KEY_PAIRS];
    logic  wr_en;

    assign o_cfg_ready = 1'b1;
    // Drop writes beyond the last key pair.
    assign wr_en = i_cfg_valid && o_cfg_ready
                   && (i_cfg_index < CFG_IDX_W'(NUM_KEY_PAIRS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_KEY_PAIRS; i++) begin
                r_key_pair[i] <= KEY_RESET[i];
            end
        end else if (wr_en) begin
            r_key_pair[i_cfg_index[KEY_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    for (genvar i = 0; i < NUM_KEY_PAIRS; i++) begin : g_key
        assign o_round_key[2*i]   = r_key_pair[i][15:0];
        assign o_round_key[2*i+1] = r_key_pair[i][31:16];
    end

endmodule

FILE: sim/tb_seed_key_feistel_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seed_key_feistel_cipher
// Self-checking bench for the seed/key Feistel cipher pipeline.
// ----------------------------------------------------------------------------
// Drives challenges through the valid/stall channel and compares every
// response with a local sixteen-round cipher computed on acceptance. The run
// steps through several round-key settings (reset keys, all zeros, all ones,
// random keys, writes to unused indexes). It idles both sides at random, and
// it applies back-pressure long enough to fill the pipeline.
// ----------------------------------------------------------------------------
module tb_seed_key_feistel_cipher;
    import skfc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PIPE_TAIL   = 12;     // tail after the last drain, past the eight-stage pipeline
    localparam int LONG_HOLD   = 100;    // cycles of forced output stall
    localparam int IDLE_PCT    = 33;

    // Register indexes: one key pair by name, and the unused range above the keys.
    localparam logic [CFG_IDX_W-1:0] IDX_KEY_PAIR_3    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] IDX_FIRST_UNUSED  = CFG_IDX_W'(NUM_KEY_PAIRS);
    localparam logic [CFG_IDX_W-1:0] IDX_LAST_UNUSED   = '1;

    // Substitution table and reset key set, kept apart from the package.
    localparam logic [3:0] SUBST_TABLE [32] = '{
        4'h5, 4'h6, 4'h7, 4'h1, 4'h9, 4'hC, 4'hD, 4'h8,
        4'hA, 4'hD, 4'h2, 4'hB, 4'hF, 4'h4, 4'h0, 4'h3,
        4'hB, 4'h4, 4'h6, 4'h0, 4'hF, 4'h2, 4'hD, 4'h9,
        4'h5, 4'hC, 4'h1, 4'hA, 4'h3, 4'hD, 4'hE, 4'h8
    };
    localparam logic [31:0] DEFAULT_KEYS [8] = '{
        32'hCA580FE9, 32'hDFF15E90, 32'hF591690B, 32'h5C7B1794,
        32'h98E5A7BF, 32'hA1C90B63, 32'hF41379BF, 32'hA89582B1
    };

    // Every input starts at a known value.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic [31:0]          i_challenge = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [31:0]          o_response;
    logic                 o_cfg_ready;

    // Local copy of the round-key registers.
    logic [31:0] round_key_regs [8];

    logic [31:0] challenge_queue [$];    // challenges waiting to be offered
    logic [31:0] pending_responses [$];  // responses owed by the block

    int send_gap_pct     = IDLE_PCT;
    int out_stall_pct    = IDLE_PCT;
    int hold_request     = 0;
    int hold_left        = 0;
    int challenges_queued = 0;
    int challenges_taken = 0;
    int responses_seen   = 0;
    int key_settings     = 1;
    int cfg_writes       = 0;
    int error_count      = 0;
    int cycle_count      = 0;

    seed_key_feistel_cipher u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_challenge (i_challenge),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_response  (o_response),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Sixteen rounds, keys 15 down to 0, then swap the halves.
    function automatic logic [31:0] feistel_response(input logic [31:0] seed);
        logic [31:0] st;
        logic [31:0] dup;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] rk;
        logic [15:0] mix;
        logic [15:0] rot;
        int          r;
        int          n;
        st = seed;
        for (r = NUM_ROUNDS - 1; r >= 0; r--) begin
            lo  = st[15:0];
            hi  = st[31:16];
            rk  = r[0] ? round_key_regs[r >> 1][31:16] : round_key_regs[r >> 1][15:0];
            dup = {lo ^ rk, lo ^ rk};
            for (n = 0; n < NUM_NIBBLES; n++) begin
                mix[4*n +: 4] = SUBST_TABLE[dup[4*n +: 5]];
            end
            rot = {mix[2:0], mix[15:3]};
            st  = {lo, rot ^ hi};
        end
        return {st[15:0], st[31:16]};
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch: %s got %08h want %08h", $realtime, what, got, want);
        error_count++;
    endtask

    // Mostly full-range seeds, with a share of sparse, half-empty and near-full patterns.
    function automatic logic [31:0] random_challenge();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom();
        else if (pick < 78)
            return $urandom_range(0, 31);
        else if (pick < 86)
            return {16'($urandom_range(0, 65535)), 16'h0000};
        else if (pick < 93)
            return 32'h1 << $urandom_range(0, 31);
        else
            return ~(32'h1 << $urandom_range(0, 31));
    endfunction

    task automatic queue_challenge(input logic [31:0] seed);
        challenge_queue.push_back(seed);
        challenges_queued++;
    endtask

    task automatic queue_random(input int count);
        repeat (count) queue_challenge(random_challenge());
    endtask

    // Wait until every queued challenge is in and every response is out.
    task automatic drain_pipeline();
        @(posedge i_clk);
        while (challenges_taken != challenges_queued || pending_responses.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_key_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx < NUM_KEY_PAIRS)
            round_key_regs[idx[KEY_IDX_W-1:0]] = data;
        cfg_writes++;
    endtask

    task automatic load_keys(input logic [31:0] k0, input logic [31:0] k1,
                             input bit use_random);
        int i;
        for (i = 0; i < NUM_KEY_PAIRS; i++)
            write_key_reg(CFG_IDX_W'(i), use_random ? $urandom() : ((i % 2) ? k1 : k0));
        key_settings++;
    endtask

    // Sender: hold a stalled item, otherwise offer the next one or idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                pending_responses.push_back(feistel_response(i_challenge));
                challenges_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (challenge_queue.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                    i_in_valid  <= 1'b1;
                    i_challenge <= challenge_queue.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall: random, or a long hold when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
            end
        end
    end

    // Response checker: compare against the oldest owed response.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            responses_seen++;
            if (pending_responses.size() == 0)
                report_mismatch("response with none owed", o_response, 32'h0);
            else if (o_response !== pending_responses[0])
                report_mismatch("response", o_response, pending_responses.pop_front());
            else
                void'(pending_responses.pop_front());
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses owed",
                     cycle_count, pending_responses.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NUM_KEY_PAIRS; i++)
            round_key_regs[i] = DEFAULT_KEYS[i];
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset keys: field extremes and window-edge patterns first.
        queue_challenge(32'h0000_0000);
        queue_challenge(32'hFFFF_FFFF);
        queue_challenge(32'h0000_0001);
        queue_challenge(32'h8000_0000);
        queue_challenge(32'h0000_FFFF);
        queue_challenge(32'hFFFF_0000);
        queue_challenge(32'hAAAA_AAAA);
        queue_challenge(32'h5555_5555);
        queue_challenge(32'h0000_001F);
        queue_challenge(32'h0000_F000);
        queue_challenge(32'h0000_8001);
        queue_challenge(32'h7FFF_FFFF);
        queue_challenge(32'hFFFF_FFFE);
        queue_challenge(32'h1234_5678);
        queue_challenge(32'hF00F_0FF0);
        queue_random(300);
        drain_pipeline();

        // All-zero keys; writes to unused indexes must leave the keys alone.
        load_keys(32'h0000_0000, 32'h0000_0000, 1'b0);
        write_key_reg(IDX_FIRST_UNUSED, 32'hFFFF_FFFF);
        write_key_reg(IDX_LAST_UNUSED, $urandom());
        cfg_writes += 0;
        queue_challenge(32'h0000_0000);
        queue_challenge(32'hFFFF_FFFF);
        queue_random(250);
        drain_pipeline();

        // All-ones keys with a long stretch of back-to-back traffic.
        load_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_gap_pct  = 0;
        out_stall_pct = 0;
        queue_random(250);
        drain_pipeline();

        // Random keys: fill the pipe behind a long output hold and drain it, then
        // run a second batch with random idling on both sides restored.
        load_keys('0, '0, 1'b1);
        hold_request = LONG_HOLD;
        queue_random(150);
        drain_pipeline();
        send_gap_pct  = IDLE_PCT;
        out_stall_pct = IDLE_PCT;
        queue_random(150);
        drain_pipeline();

        // Mixed keys, then an unused-index write and a key pair 3 write with random data.
        load_keys(32'hFFFF_0000, 32'h0000_FFFF, 1'b0);
        write_key_reg(IDX_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, 7)), $urandom());
        write_key_reg(IDX_KEY_PAIR_3, $urandom());
        queue_random(300);
        drain_pipeline();

        // Back to the reset key set, by writing it explicitly.
        for (int i = 0; i < NUM_KEY_PAIRS; i++)
            write_key_reg(CFG_IDX_W'(i), DEFAULT_KEYS[i]);
        key_settings++;
        queue_random(280);
        drain_pipeline();

        repeat (PIPE_TAIL) @(posedge i_clk);
        $display("Run covered %0d challenges and %0d responses over %0d key settings,",
                 challenges_taken, responses_seen, key_settings);
        $display("with %0d register writes and %0d mismatches.", cfg_writes, error_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
